FILE: design/ppa_pkg.sv
// shared types, codes and a helper function for the peripheral pool allocator
package ppa_pkg;

  // largest pool any instance may have, and width of a unit count over it
  localparam int MAX_POOL = 16;
  localparam int CNT_W    = 5;
  // width of the request counts and of the unit fields on the ports
  localparam int WANT_W   = 4;
  localparam int UNIT_W   = 8;
  localparam int ID_W     = 8;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_GRANT   = 2'd0,
    ST_REFUSE  = 2'd1,
    ST_RELEASE = 2'd2
  } status_t;

  // commit strobes from the top level to one pool
  typedef struct packed {
    logic grab;
    logic release_all;
  } pool_cmd_t;

  // what one pool reports for the item under work
  typedef struct packed {
    logic                enough;
    logic [MAX_POOL-1:0] grab_units;
    logic [MAX_POOL-1:0] rel_units;
  } pool_res_t;

  function automatic logic [CNT_W-1:0] count_ones(input logic [MAX_POOL-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int k = 0; k < MAX_POOL; k++) begin
      n = n + CNT_W'(v[k]);
    end
    return n;
  endfunction

endpackage

FILE: design/ppa_pool.sv
// one device pool: busy marks, owner ids, free check, first-free pick, owner match
module ppa_pool #(
  parameter int SIZE       = 8,
  parameter int OWNER_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ppa_pkg::pool_cmd_t            cmd,
  input  logic [ppa_pkg::WANT_W-1:0]    want,
  input  logic [OWNER_BITS-1:0]         who,
  output ppa_pkg::pool_res_t            res
);

  logic [SIZE-1:0]           busy;
  logic [OWNER_BITS-1:0]     owner [SIZE];
  logic [SIZE-1:0]           free_units;
  logic [SIZE-1:0]           grab_mask;
  logic [SIZE-1:0]           rel_mask;
  logic [ppa_pkg::CNT_W-1:0] free_cnt;
  logic [ppa_pkg::CNT_W-1:0] want_cnt;
  logic [ppa_pkg::MAX_POOL-1:0] free_wide;

  assign free_units = ~busy;
  assign want_cnt   = ppa_pkg::CNT_W'(want);

  always_comb begin
    free_wide = '0;
    free_wide[SIZE-1:0] = free_units;
  end

  assign free_cnt = ppa_pkg::count_ones(free_wide);

  // unit i is taken when it is free and fewer than want free units lie below it
  for (genvar i = 0; i < SIZE; i++) begin : g_unit
    logic [SIZE-1:0]              below;
    logic [ppa_pkg::MAX_POOL-1:0] below_wide;
    logic [ppa_pkg::CNT_W-1:0]    rank;

    assign below = free_units & ((SIZE'(1) << i) - SIZE'(1));

    always_comb begin
      below_wide = '0;
      below_wide[SIZE-1:0] = below;
    end

    assign rank         = ppa_pkg::count_ones(below_wide);
    assign grab_mask[i] = free_units[i] && (rank < want_cnt);
    assign rel_mask[i]  = busy[i] && (owner[i] == who);
  end

  always_comb begin
    res = '0;
    res.enough = (want == '0) || (free_cnt >= want_cnt);
    res.grab_units[SIZE-1:0] = grab_mask;
    res.rel_units[SIZE-1:0]  = rel_mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (cmd.grab) begin
      busy <= busy | grab_mask;
    end else if (cmd.release_all) begin
      busy <= busy & ~rel_mask;
    end
  end

  // owner ids are payload; only read while the busy mark is set
  always_ff @(posedge clk) begin
    for (int k = 0; k < SIZE; k++) begin
      if (cmd.grab && grab_mask[k]) begin
        owner[k] <= who;
      end
    end
  end

endmodule

FILE: design/peripheral_pool_allocator.sv
// top level of the all-or-nothing peripheral pool allocator
// Takes one request per cycle while out_ready keeps results draining, and returns
// exactly one result per request: the request is captured in an input register,
// checked and committed against the four pools once the output register is empty
// or drains, and the result sits in an output register until its transfer. An
// allocate request is granted only when every pool asked for a nonzero count has
// that many free units; then the lowest-indexed free units of each pool are marked
// for the owner, otherwise nothing changes. A release request frees every unit the
// owner holds in all pools. The unit fields show units zero to seven of each pool.
// The state of all pools lives in flip-flops, so free counts, unit picks and owner
// matches for a request finish in the commit cycle and the next request sees the
// updated pools. in_ready follows out_ready in the same cycle when both registers
// are full; there is no clearing pass after reset.
module peripheral_pool_allocator #(
  parameter int CD_POOL      = 8,
  parameter int MODEM_POOL   = 8,
  parameter int PRINTER_POOL = 8,
  parameter int SCANNER_POOL = 8,
  parameter int OWNER_BITS   = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        op,
  input  logic [ppa_pkg::ID_W-1:0]    owner_id,
  input  logic [ppa_pkg::WANT_W-1:0]  want_cds,
  input  logic [ppa_pkg::WANT_W-1:0]  want_modems,
  input  logic [ppa_pkg::WANT_W-1:0]  want_printers,
  input  logic [ppa_pkg::WANT_W-1:0]  want_scanners,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [ppa_pkg::UNIT_W-1:0]  cd_units,
  output logic [ppa_pkg::UNIT_W-1:0]  modem_units,
  output logic [ppa_pkg::UNIT_W-1:0]  printer_units,
  output logic [ppa_pkg::UNIT_W-1:0]  scanner_units
);

  // input register: request waiting for its commit cycle
  logic                       s1_valid;
  ppa_pkg::op_t               s1_op;
  logic [OWNER_BITS-1:0]      s1_owner;
  logic [ppa_pkg::WANT_W-1:0] s1_want_cd;
  logic [ppa_pkg::WANT_W-1:0] s1_want_modem;
  logic [ppa_pkg::WANT_W-1:0] s1_want_printer;
  logic [ppa_pkg::WANT_W-1:0] s1_want_scanner;

  // output register
  ppa_pkg::status_t           status_q;
  logic [ppa_pkg::UNIT_W-1:0] cd_q;
  logic [ppa_pkg::UNIT_W-1:0] modem_q;
  logic [ppa_pkg::UNIT_W-1:0] printer_q;
  logic [ppa_pkg::UNIT_W-1:0] scanner_q;

  ppa_pkg::pool_cmd_t cmd;
  ppa_pkg::pool_res_t cd_res;
  ppa_pkg::pool_res_t modem_res;
  ppa_pkg::pool_res_t printer_res;
  ppa_pkg::pool_res_t scanner_res;

  logic             advance;
  logic             grant_ok;
  ppa_pkg::status_t status_next;
  logic [ppa_pkg::MAX_POOL-1:0] cd_sel;
  logic [ppa_pkg::MAX_POOL-1:0] modem_sel;
  logic [ppa_pkg::MAX_POOL-1:0] printer_sel;
  logic [ppa_pkg::MAX_POOL-1:0] scanner_sel;

  // commit when the output register is empty or drains this cycle
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // all-or-nothing: every pool must have room
  assign grant_ok = cd_res.enough && modem_res.enough &&
                    printer_res.enough && scanner_res.enough;

  assign cmd.grab        = advance && (s1_op == ppa_pkg::OP_ALLOC) && grant_ok;
  assign cmd.release_all = advance && (s1_op == ppa_pkg::OP_RELEASE);

  ppa_pool #(.SIZE(CD_POOL), .OWNER_BITS(OWNER_BITS)) u_cd (
    .clk(clk), .rst(rst), .cmd(cmd), .want(s1_want_cd), .who(s1_owner), .res(cd_res)
  );

  ppa_pool #(.SIZE(MODEM_POOL), .OWNER_BITS(OWNER_BITS)) u_modem (
    .clk(clk), .rst(rst), .cmd(cmd), .want(s1_want_modem), .who(s1_owner),
    .res(modem_res)
  );

  ppa_pool #(.SIZE(PRINTER_POOL), .OWNER_BITS(OWNER_BITS)) u_printer (
    .clk(clk), .rst(rst), .cmd(cmd), .want(s1_want_printer), .who(s1_owner),
    .res(printer_res)
  );

  ppa_pool #(.SIZE(SCANNER_POOL), .OWNER_BITS(OWNER_BITS)) u_scanner (
    .clk(clk), .rst(rst), .cmd(cmd), .want(s1_want_scanner), .who(s1_owner),
    .res(scanner_res)
  );

  // pick the unit masks and status for the result
  always_comb begin
    cd_sel      = '0;
    modem_sel   = '0;
    printer_sel = '0;
    scanner_sel = '0;
    if (s1_op == ppa_pkg::OP_RELEASE) begin
      status_next = ppa_pkg::ST_RELEASE;
      cd_sel      = cd_res.rel_units;
      modem_sel   = modem_res.rel_units;
      printer_sel = printer_res.rel_units;
      scanner_sel = scanner_res.rel_units;
    end else if (grant_ok) begin
      status_next = ppa_pkg::ST_GRANT;
      cd_sel      = cd_res.grab_units;
      modem_sel   = modem_res.grab_units;
      printer_sel = printer_res.grab_units;
      scanner_sel = scanner_res.grab_units;
    end else begin
      // refused: nothing taken, nothing shown
      status_next = ppa_pkg::ST_REFUSE;
    end
  end

  // control: input and output valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // input register payload, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op           <= ppa_pkg::op_t'(op);
      s1_owner        <= OWNER_BITS'(owner_id);
      s1_want_cd      <= want_cds;
      s1_want_modem   <= want_modems;
      s1_want_printer <= want_printers;
      s1_want_scanner <= want_scanners;
    end
  end

  // result register payload, loaded in the commit cycle
  always_ff @(posedge clk) begin
    if (advance) begin
      status_q  <= status_next;
      cd_q      <= cd_sel[ppa_pkg::UNIT_W-1:0];
      modem_q   <= modem_sel[ppa_pkg::UNIT_W-1:0];
      printer_q <= printer_sel[ppa_pkg::UNIT_W-1:0];
      scanner_q <= scanner_sel[ppa_pkg::UNIT_W-1:0];
    end
  end

  assign status        = status_q;
  assign cd_units      = cd_q;
  assign modem_units   = modem_q;
  assign printer_units = printer_q;
  assign scanner_units = scanner_q;

  // a refused request shows no units
  a_refuse_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status_q == ppa_pkg::ST_REFUSE)) |->
      ((cd_q == '0) && (modem_q == '0) && (printer_q == '0) && (scanner_q == '0)))
    else $error("refused result carries units");

  // a grant takes exactly the requested count from each pool
  a_grant_count: assert property (@(posedge clk) disable iff (rst)
    cmd.grab |->
      (($countones(cd_res.grab_units) == ppa_pkg::CNT_W'(s1_want_cd)) &&
       ($countones(modem_res.grab_units) == ppa_pkg::CNT_W'(s1_want_modem)) &&
       ($countones(printer_res.grab_units) == ppa_pkg::CNT_W'(s1_want_printer)) &&
       ($countones(scanner_res.grab_units) == ppa_pkg::CNT_W'(s1_want_scanner))))
    else $error("granted unit count differs from request");

  // a request blocked by a full output register keeps its payload
  a_hold_s1: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_owner) && $stable(s1_op)))
    else $error("stalled request changed");

  // a result waiting for its transfer is not overwritten
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !advance)
    else $error("pending result overwritten");

endmodule

FILE: sim/peripheral_pool_allocator_tb.sv
// self-checking testbench for the peripheral pool allocator: directed and random requests
module peripheral_pool_allocator_tb;
  import ppa_pkg::*;

  localparam int POOLS = 4;
  localparam int UNITS = 8;
  localparam int RANDOM_REQUESTS = 1900;

  // one request as the driver presents it, plus pacing marks
  typedef struct packed {
    logic                          drain;  // hold off until all grants are back
    logic [1:0]                    phase;  // idling profile
    op_t                           op;
    logic [ID_W-1:0]               owner;
    logic [POOLS-1:0][WANT_W-1:0]  want;   // [0] cds .. [3] scanners
  } request_t;

  // one result: status and the units touched per pool
  typedef struct packed {
    status_t                       status;
    logic [POOLS-1:0][UNIT_W-1:0]  units;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic              op            = 1'b0;
  logic [ID_W-1:0]   owner_id      = '0;
  logic [WANT_W-1:0] want_cds      = '0;
  logic [WANT_W-1:0] want_modems   = '0;
  logic [WANT_W-1:0] want_printers = '0;
  logic [WANT_W-1:0] want_scanners = '0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic [1:0]        status;
  logic [UNIT_W-1:0] cd_units;
  logic [UNIT_W-1:0] modem_units;
  logic [UNIT_W-1:0] printer_units;
  logic [UNIT_W-1:0] scanner_units;

  peripheral_pool_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .owner_id      (owner_id),
    .want_cds      (want_cds),
    .want_modems   (want_modems),
    .want_printers (want_printers),
    .want_scanners (want_scanners),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .cd_units      (cd_units),
    .modem_units   (modem_units),
    .printer_units (printer_units),
    .scanner_units (scanner_units)
  );

  always #2 clk = ~clk;

  // shadow copy of the pools
  logic            unit_busy  [POOLS][UNITS];
  logic [ID_W-1:0] unit_owner [POOLS][UNITS];

  request_t pending_requests[$];
  grant_t   expected_grants[$];
  request_t on_wire;
  logic [1:0] phase_q = 2'd0;
  int failures = 0;

  string pool_name [POOLS] = '{"cd", "modem", "printer", "scanner"};

  // idle chance in percent: sender/receiver 30/49, then 49/30, then none
  function automatic int idle_pct(input logic [1:0] ph, input logic sender);
    case (ph)
      2'd0: return sender ? 30 : 49;
      2'd1: return sender ? 49 : 30;
      default: return 0;
    endcase
  endfunction

  // apply one request to the shadow pools and return the grant it yields
  function automatic grant_t allocate_or_release(input request_t r);
    grant_t g;
    int     free_units;
    int     taken;
    logic   fits;
    g.units = '0;
    if (r.op == OP_RELEASE) begin
      for (int p = 0; p < POOLS; p++) begin
        for (int i = 0; i < UNITS; i++) begin
          if (unit_busy[p][i] && unit_owner[p][i] == r.owner) begin
            unit_busy[p][i] = 1'b0;
            g.units[p][i] = 1'b1;
          end
        end
      end
      g.status = ST_RELEASE;
    end else begin
      // all-or-nothing: a zero count never blocks the request
      fits = 1'b1;
      for (int p = 0; p < POOLS; p++) begin
        free_units = 0;
        for (int i = 0; i < UNITS; i++) begin
          if (!unit_busy[p][i]) free_units++;
        end
        if (r.want[p] != 0 && free_units < int'(r.want[p])) fits = 1'b0;
      end
      if (fits) begin
        // lowest-indexed free units go first
        for (int p = 0; p < POOLS; p++) begin
          taken = 0;
          for (int i = 0; i < UNITS; i++) begin
            if (!unit_busy[p][i] && taken < int'(r.want[p])) begin
              unit_busy[p][i] = 1'b1;
              unit_owner[p][i] = r.owner;
              g.units[p][i] = 1'b1;
              taken++;
            end
          end
        end
        g.status = ST_GRANT;
      end else begin
        g.status = ST_REFUSE;
      end
    end
    return g;
  endfunction

  task automatic queue_request(input op_t o, input logic [ID_W-1:0] who,
                               input int cds, input int modems, input int printers,
                               input int scanners, input logic [1:0] ph, input logic drain);
    request_t r;
    r.drain = drain;
    r.phase = ph;
    r.op    = o;
    r.owner = who;
    r.want  = {WANT_W'(scanners), WANT_W'(printers), WANT_W'(modems), WANT_W'(cds)};
    pending_requests.push_back(r);
  endtask

  // driver: predicts on each input transfer, then loads the next request or idles
  always @(posedge clk) begin
    logic next_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_grants.push_back(allocate_or_release(on_wire));
      end
      if (!in_valid || in_ready) begin
        next_valid = 1'b0;
        if (pending_requests.size() != 0 &&
            !(pending_requests[0].drain && expected_grants.size() != 0) &&
            $urandom_range(99) >= idle_pct(pending_requests[0].phase, 1'b1)) begin
          on_wire = pending_requests.pop_front();
          next_valid = 1'b1;
          op            <= on_wire.op;
          owner_id      <= on_wire.owner;
          want_cds      <= on_wire.want[0];
          want_modems   <= on_wire.want[1];
          want_printers <= on_wire.want[2];
          want_scanners <= on_wire.want[3];
          phase_q       <= on_wire.phase;
        end
        in_valid <= next_valid;
      end
    end
  end

  // monitor: checks each output transfer against the oldest expected grant
  always @(posedge clk) begin
    grant_t got;
    grant_t want_g;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.status = status_t'(status);
        got.units  = {scanner_units, printer_units, modem_units, cd_units};
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected result status %0d", $time, status);
          failures++;
        end else begin
          want_g = expected_grants.pop_front();
          if (got.status !== want_g.status) begin
            $display("%0t: status mismatch expected %0d got %0d",
                     $time, want_g.status, got.status);
            failures++;
          end
          for (int p = 0; p < POOLS; p++) begin
            if (got.units[p] !== want_g.units[p]) begin
              $display("%0t: %s units mismatch expected %b got %b",
                       $time, pool_name[p], want_g.units[p], got.units[p]);
              failures++;
            end
          end
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct(phase_q, 1'b0));
    end
  end

  initial begin
    logic [ID_W-1:0] owners [6];
    logic [1:0]      ph;
    int              pick;
    int              counts [POOLS];
    for (int p = 0; p < POOLS; p++) begin
      for (int i = 0; i < UNITS; i++) begin
        unit_busy[p][i]  = 1'b0;
        unit_owner[p][i] = '0;
      end
    end

    // directed: empty and full requests, refusals, holes refilled lowest first
    queue_request(OP_ALLOC,   8'h00, 0, 0, 0, 0, 2'd0, 1'b0);
    queue_request(OP_ALLOC,   8'hFF, 8, 8, 8, 8, 2'd0, 1'b0);
    queue_request(OP_ALLOC,   8'h01, 1, 0, 0, 0, 2'd0, 1'b0);   // pools full
    queue_request(OP_ALLOC,   8'h01, 0, 0, 0, 0, 2'd0, 1'b0);   // zero count passes when full
    queue_request(OP_RELEASE, 8'h55, 15, 15, 15, 15, 2'd0, 1'b0); // owner holds nothing
    queue_request(OP_RELEASE, 8'hFF, 15, 15, 15, 15, 2'd0, 1'b0);
    queue_request(OP_ALLOC,   8'hAA, 15, 0, 0, 0, 2'd0, 1'b0);  // above pool size
    queue_request(OP_ALLOC,   8'hAA, 0, 9, 0, 0, 2'd0, 1'b0);
    queue_request(OP_ALLOC,   8'hAA, 0, 0, 12, 3, 2'd0, 1'b0);
    queue_request(OP_ALLOC,   8'h11, 3, 2, 1, 8, 2'd0, 1'b0);
    queue_request(OP_ALLOC,   8'h22, 2, 2, 2, 0, 2'd0, 1'b0);
    queue_request(OP_RELEASE, 8'h11, 0, 0, 0, 0, 2'd0, 1'b0);
    queue_request(OP_ALLOC,   8'h33, 4, 4, 4, 1, 2'd0, 1'b0);
    queue_request(OP_ALLOC,   8'h44, 0, 0, 0, 8, 2'd0, 1'b0);   // one short on scanners
    queue_request(OP_ALLOC,   8'h44, 0, 0, 0, 7, 2'd0, 1'b0);
    queue_request(OP_ALLOC,   8'h44, 2, 0, 0, 0, 2'd0, 1'b0);
    queue_request(OP_RELEASE, 8'h22, 0, 0, 0, 0, 2'd0, 1'b0);
    queue_request(OP_RELEASE, 8'h33, 0, 0, 0, 0, 2'd0, 1'b0);
    queue_request(OP_ALLOC,   8'h00, 1, 1, 1, 1, 2'd0, 1'b0);
    queue_request(OP_RELEASE, 8'h44, 0, 0, 0, 0, 2'd0, 1'b0);
    queue_request(OP_RELEASE, 8'h00, 0, 0, 0, 0, 2'd0, 1'b0);

    // a small set of owners so releases usually find something to free
    owners[0] = 8'h00;
    owners[1] = 8'hFF;
    for (int k = 2; k < 6; k++) owners[k] = ID_W'($urandom);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      ph = (n < 650) ? 2'd0 : (n < 1300) ? 2'd1 : 2'd2;
      pick = $urandom_range(99);
      if (pick < 5) begin
        // noise: any op, any owner, any count the fields allow
        queue_request(op_t'($urandom_range(1)), ID_W'($urandom),
                      $urandom_range(15), $urandom_range(15), $urandom_range(15),
                      $urandom_range(15), ph, n == 0 || n == 650 || n == 1300);
      end else if (pick < 40) begin
        queue_request(OP_RELEASE, owners[$urandom_range(5)], $urandom_range(15),
                      $urandom_range(15), $urandom_range(15), $urandom_range(15),
                      ph, n == 0 || n == 650 || n == 1300);
      end else begin
        for (int p = 0; p < POOLS; p++) begin
          pick = $urandom_range(99);
          counts[p] = (pick < 40) ? 0 :
                      (pick < 88) ? $urandom_range(3, 1) :
                      (pick < 97) ? $urandom_range(8, 4) : $urandom_range(15, 9);
        end
        queue_request(OP_ALLOC, owners[$urandom_range(5)], counts[0], counts[1],
                      counts[2], counts[3], ph, n == 0 || n == 650 || n == 1300);
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || in_valid || expected_grants.size() != 0)
      @(posedge clk);
    // let any stray result show up
    repeat (10) @(posedge clk);

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
